### design/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texel sampler
// Texture geometry, fixed-point constants, action codes and the word that
// travels through the queue between the front and back parts.
// ----------------------------------------------------------------------------
package bts_pkg;

	// texture geometry
	localparam int MAX_SIDE = 256;
	localparam int TEXELS   = 65536;
	localparam int SIDE_W   = 9;
	localparam int ADDR_W   = $clog2(TEXELS);

	// fixed point
	localparam int COORD_W = 17;
	localparam int FRAC_W  = 16;
	localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(1 << FRAC_W);

	// action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                         sample;
		logic [ADDR_W-1:0]            waddr;
		logic [7:0]                   wdata;
		logic [3:0][ADDR_W-1:0]       addr;   // c00, c10, c01, c11
		logic [FRAC_W-1:0]            fx;
		logic [FRAC_W-1:0]            fy;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/bts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_front: input stage of the bilinear texel sampler
// Accepts words, scales the coordinates by the texture size and forms the
// four clamped texel addresses before handing the word to the queue.
// ----------------------------------------------------------------------------
module bts_front import bts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SIDE_W-1:0]   side_w,
	input  logic [SIDE_W-1:0]   side_h,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [15:0]         texel_index,
	input  logic [7:0]          texel_value,
	input  logic [COORD_W-1:0]  u_coord,
	input  logic [COORD_W-1:0]  v_coord,
	input  q_stat_t             q_stat,
	output logic                q_push,
	output q_entry_t            q_data
);

	localparam int PROD_W = COORD_W + SIDE_W;
	localparam int INT_W  = PROD_W - FRAC_W;
	localparam int ROW_W  = 2 * SIDE_W;

	logic                adv;
	logic                valid_s1;
	logic                action_s1;
	logic [15:0]         index_s1;
	logic [7:0]          value_s1;
	logic [PROD_W-1:0]   x_s1;
	logic [PROD_W-1:0]   y_s1;

	logic [COORD_W-1:0]  u_sat;
	logic [COORD_W-1:0]  v_sat;
	logic [INT_W-1:0]    xi, yi, xi1, yi1;
	logic [SIDE_W-1:0]   wm1, hm1;
	logic [SIDE_W-1:0]   x0, x1, y0, y1;
	logic [ROW_W-1:0]    row0, row1;

	// hold the stage while the queue is full
	assign adv      = !valid_s1 || !q_stat.full;
	assign in_stall = !adv;
	assign q_push   = valid_s1 && !q_stat.full;

	assign u_sat = (u_coord > ONE_Q16) ? ONE_Q16 : u_coord;
	assign v_sat = (v_coord > ONE_Q16) ? ONE_Q16 : v_coord;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			action_s1 <= action;
			index_s1  <= texel_index;
			value_s1  <= texel_value;
			x_s1      <= PROD_W'(u_sat) * PROD_W'(side_w);
			y_s1      <= PROD_W'(v_sat) * PROD_W'(side_h);
		end
	end

	// split, clamp to edge and form row-major addresses
	always_comb begin
		xi  = x_s1[PROD_W-1:FRAC_W];
		yi  = y_s1[PROD_W-1:FRAC_W];
		xi1 = xi + INT_W'(1);
		yi1 = yi + INT_W'(1);
		wm1 = side_w - SIDE_W'(1);
		hm1 = side_h - SIDE_W'(1);
		x0  = (xi  > INT_W'(wm1)) ? wm1 : xi[SIDE_W-1:0];
		x1  = (xi1 > INT_W'(wm1)) ? wm1 : xi1[SIDE_W-1:0];
		y0  = (yi  > INT_W'(hm1)) ? hm1 : yi[SIDE_W-1:0];
		y1  = (yi1 > INT_W'(hm1)) ? hm1 : yi1[SIDE_W-1:0];
		row0 = ROW_W'(y0) * ROW_W'(side_w);
		row1 = ROW_W'(y1) * ROW_W'(side_w);

		q_data.sample  = (action_s1 == ACT_SAMPLE);
		q_data.waddr   = index_s1[ADDR_W-1:0];
		q_data.wdata   = value_s1;
		q_data.addr[0] = ADDR_W'(row0 + ROW_W'(x0));
		q_data.addr[1] = ADDR_W'(row0 + ROW_W'(x1));
		q_data.addr[2] = ADDR_W'(row1 + ROW_W'(x0));
		q_data.addr[3] = ADDR_W'(row1 + ROW_W'(x1));
		q_data.fx      = x_s1[FRAC_W-1:0];
		q_data.fy      = y_s1[FRAC_W-1:0];
	end

endmodule

### design/bts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_queue: short queue between front and back
// Registered FIFO that lets the front and back parts stall on their own.
// ----------------------------------------------------------------------------
module bts_queue import bts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_entry_t  pop_data,
	output q_stat_t   stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/bts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_back: texture store and bilinear blend
// Four copies of the texture give four reads a cycle; two multiply stages
// blend the texels and the output register holds the rounded result.
// ----------------------------------------------------------------------------
module bts_back import bts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  q_entry_t  q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output logic [7:0] alpha_out
);

	localparam int MIX_W = 8 + FRAC_W;           // Q8.16 row blend
	localparam int SUM_W = MIX_W + FRAC_W + 1;   // Q8.32 plus headroom
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (2 * FRAC_W - 1);

	logic                 adv;
	logic                 valid_s1, valid_s2, out_valid_q;
	logic [3:0][7:0]      texel_s1;
	logic [FRAC_W-1:0]    fx_s1, fy_s1, fy_s2;
	logic [MIX_W-1:0]     top_s2, bot_s2;
	logic [7:0]           alpha_q;
	logic [COORD_W-1:0]   omfx, omfy;
	logic [SUM_W-1:0]     blend;

	// advance the whole back part unless a finished word is held
	assign adv       = !out_valid_q || !out_stall;
	assign q_pop     = adv && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign alpha_out = alpha_q;

	// texture copies: every write goes to all four
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] bank_mem [TEXELS];

		always_ff @(posedge clk) begin
			if (q_pop && !q_data.sample) begin
				bank_mem[q_data.waddr] <= q_data.wdata;
			end
			if (adv) begin
				texel_s1[b] <= bank_mem[q_data.addr[b]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_pop && q_data.sample;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign omfx  = ONE_Q16 - COORD_W'(fx_s1);
	assign omfy  = ONE_Q16 - COORD_W'(fy_s2);
	assign blend = SUM_W'(top_s2) * SUM_W'(omfy) + SUM_W'(bot_s2) * SUM_W'(fy_s2) + HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1   <= q_data.fx;
			fy_s1   <= q_data.fy;
			fy_s2   <= fy_s1;
			top_s2  <= MIX_W'(MIX_W'(texel_s1[0]) * MIX_W'(omfx)
				+ MIX_W'(texel_s1[1]) * MIX_W'(fx_s1));
			bot_s2  <= MIX_W'(MIX_W'(texel_s1[2]) * MIX_W'(omfx)
				+ MIX_W'(texel_s1[3]) * MIX_W'(fx_s1));
			alpha_q <= blend[2*FRAC_W+7:2*FRAC_W];
		end
	end

endmodule

### design/bilinear_texel_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texel_sampler: 8-bit texture store with bilinear sampling
// Write words load texels at a linear index; sample words return one
// clamp-to-edge bilinear blend rounded half up to 0..255.
// ----------------------------------------------------------------------------
// The block takes one word every cycle while in_stall is low, writes and
// samples mixed freely, and returns one alpha word per sample in order;
// writes give no result. A sample sees every write accepted before it. From
// acceptance to result a word passes the front stage forming coordinates and
// addresses, the queue, the texture read, the horizontal blend and the
// vertical blend into the output register. The one-word-per-cycle rate comes
// from holding four full copies of the texture, each with one write and one
// read port, so all four neighbours are read at once. Set width and height
// (register 0 and 1, reset 1) only while the block is idle; zero acts as 1
// and sizes above 256 act as 256. Coordinates above 1.0 are saturated. The
// store is not cleared at reset: sample only written texels.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler import bts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SIDE_W-1:0]   cfg_data,
	// input words
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [15:0]         texel_index,
	input  logic [7:0]          texel_value,
	input  logic [COORD_W-1:0]  u_coord,
	input  logic [COORD_W-1:0]  v_coord,
	// result words
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          alpha_out
);

	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [SIDE_W-1:0] side_w;
	logic [SIDE_W-1:0] side_h;
	logic              q_push;
	logic              q_pop;
	q_entry_t          q_in;
	q_entry_t          q_out;
	q_stat_t           q_stat;

	// hold the raw register values; the reset size is one texel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// map an empty size to one texel and cap at the largest side
	always_comb begin
		side_w = width_q;
		side_h = height_q;
		if (width_q == '0) begin
			side_w = SIDE_W'(1);
		end else if (width_q > SIDE_W'(MAX_SIDE)) begin
			side_w = SIDE_W'(MAX_SIDE);
		end
		if (height_q == '0) begin
			side_h = SIDE_W'(1);
		end else if (height_q > SIDE_W'(MAX_SIDE)) begin
			side_h = SIDE_W'(MAX_SIDE);
		end
	end

	// front: scale, split and address
	bts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_w      (side_w),
		.side_h      (side_h),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.texel_index (texel_index),
		.texel_value (texel_value),
		.u_coord     (u_coord),
		.v_coord     (v_coord),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	// decouple front from back
	bts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.stat      (q_stat)
	);

	// back: store, read four neighbours, blend, round
	bts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.alpha_out (alpha_out)
	);

endmodule
